// ===== design/qde_pkg.sv =====
package qde_pkg;

  // sizes of the request and result fields
  localparam int NUM_PORTS    = 4;
  localparam int PORT_W       = 2;
  localparam int BYTES_W      = 16;
  localparam int MAX_SNAPSHOT = 1024;
  localparam int CNT_W        = 11;
  localparam int DELAY_W      = 40;

  // accumulator and divider widths
  localparam int RUN_W  = 27;
  localparam int PSUM_W = 37;
  localparam int FRAC_W = 8;
  localparam int DIVD_W = PSUM_W + FRAC_W;
  localparam int STEP_W = $clog2(DIVD_W);

  // scaling by the per-byte time, split into two partial products
  localparam int NS_W      = 24;
  localparam int NS_FRAC_W = 16;
  localparam int MUL_LO_W  = 23;
  localparam int MUL_HI_W  = DIVD_W - MUL_LO_W;
  localparam int PROD_W    = MUL_LO_W + NS_W;
  localparam int HI_PROD_W = MUL_HI_W + NS_W;
  localparam int SCALE_W   = HI_PROD_W + MUL_LO_W - NS_FRAC_W + 1;

  // smoothing weights in 1/256 units
  localparam int WGT_W    = 8;
  localparam int OLD_PR_W = DELAY_W + WGT_W;
  localparam int NEW_PR_W = DELAY_W + 6;
  localparam int WSUM_W   = OLD_PR_W + 1;
  localparam logic [WGT_W-1:0] W_OLD = 8'd205;
  localparam logic [WGT_W-1:0] W_NEW = 8'd51;

  // register port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_NS_PER_BYTE = 1'b0;
  localparam logic [NS_W-1:0]      NS_RESET        = 24'd256128;

  // commands from the controller
  typedef struct packed {
    logic acc_en;
    logic div_load;
    logic div_step;
    logic mul_lo;
    logic mul_hi;
    logic scale;
    logic w_old;
    logic w_new;
    logic emit;
  } qde_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic div_last;
    logic out_free;
  } qde_sts_t;

endpackage

// ===== design/qde_in_if.sv =====
interface qde_in_if import qde_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PORT_W-1:0]  port_index;
  logic [BYTES_W-1:0] packet_bytes;
  logic               last_in_snapshot;

  modport source (output valid, port_index, packet_bytes, last_in_snapshot, input ready);
  modport sink   (input valid, port_index, packet_bytes, last_in_snapshot, output ready);
endinterface

// ===== design/qde_out_if.sv =====
interface qde_out_if import qde_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PORT_W-1:0]  port_out;
  logic [DELAY_W-1:0] sample_delay_q8;
  logic [DELAY_W-1:0] smoothed_delay_q8;
  logic [CNT_W-1:0]   packets_counted;

  modport source (output valid, port_out, sample_delay_q8, smoothed_delay_q8,
                  packets_counted, input ready);
  modport sink   (input valid, port_out, sample_delay_q8, smoothed_delay_q8,
                  packets_counted, output ready);
endinterface

// ===== design/qde_ctrl.sv =====
module qde_ctrl import qde_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_ready_o,
  input  qde_sts_t sts_i,
  output qde_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_ACCUM  = 8'b0000_0001,
    ST_DIV    = 8'b0000_0010,
    ST_MUL_LO = 8'b0000_0100,
    ST_MUL_HI = 8'b0000_1000,
    ST_SCALE  = 8'b0001_0000,
    ST_W_OLD  = 8'b0010_0000,
    ST_W_NEW  = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_ACCUM: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.acc_en = 1'b1;
          if (in_last_i) begin
            cmd_o.div_load = 1'b1;
            state_d        = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_W_OLD;
      end
      ST_W_OLD: begin
        cmd_o.w_old = 1'b1;
        state_d     = ST_W_NEW;
      end
      ST_W_NEW: begin
        cmd_o.w_new = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_ACCUM;
        end
      end
      default: begin
        state_d = ST_ACCUM;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
    end else begin
      state_q <= state_d;
    end
  end

  // the last packet of a snapshot always starts a divide
  a_last_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_load |=> state_q == ST_DIV)
    else $error("divide not started after last packet");

  // the divide runs until its final step
  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && !sts_i.div_last |=> state_q == ST_DIV)
    else $error("divide left early");

endmodule

// ===== design/qde_dpath.sv =====
module qde_dpath import qde_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qde_cmd_t           cmd_i,
  output qde_sts_t           sts_o,
  input  logic [NS_W-1:0]    ns_per_byte_i,
  input  logic [PORT_W-1:0]  in_port_i,
  input  logic [BYTES_W-1:0] in_bytes_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PORT_W-1:0]  out_port_o,
  output logic [DELAY_W-1:0] out_sample_o,
  output logic [DELAY_W-1:0] out_smoothed_o,
  output logic [CNT_W-1:0]   out_count_o
);

  // snapshot accumulators
  logic [RUN_W-1:0]  run_q;
  logic [PSUM_W-1:0] psum_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              cnt_full;
  logic [RUN_W-1:0]  run_sum;
  logic [PSUM_W-1:0] psum_sum;
  logic [PSUM_W-1:0] psum_take;
  logic [CNT_W-1:0]  cnt_take;

  // divider
  logic [DIVD_W-1:0] quot_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  divisor_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              quot_bit;

  // scaling
  logic [MUL_LO_W-1:0]  mul_a;
  logic [PROD_W-1:0]    prod;
  logic [PROD_W-1:0]    lo_prod_q;
  logic [HI_PROD_W-1:0] hi_prod_q;
  logic [SCALE_W-1:0]   scaled;
  logic [DELAY_W-1:0]   sample_q;

  // smoothing
  logic [DELAY_W-1:0]  store_q [NUM_PORTS];
  logic [PORT_W-1:0]   port_q;
  logic [DELAY_W-1:0]  old_val;
  logic                old_zero_q;
  logic [OLD_PR_W-1:0] old_prod_q;
  logic [NEW_PR_W-1:0] new_prod_q;
  logic [WSUM_W-1:0]   wsum;
  logic [DELAY_W-1:0]  blended;
  logic [DELAY_W-1:0]  upd;

  // result register
  logic               out_valid_q;
  logic [PORT_W-1:0]  out_port_q;
  logic [DELAY_W-1:0] out_sample_q;
  logic [DELAY_W-1:0] out_smoothed_q;
  logic [CNT_W-1:0]   out_count_q;

  // per-packet prefix sums, held once the count saturates
  assign cnt_full  = cnt_q >= CNT_W'(MAX_SNAPSHOT);
  assign run_sum   = run_q + RUN_W'(in_bytes_i);
  assign psum_sum  = psum_q + PSUM_W'(run_sum);
  assign psum_take = cnt_full ? psum_q : psum_sum;
  assign cnt_take  = cnt_full ? cnt_q : cnt_q + CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      psum_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.acc_en) begin
      if (cmd_i.div_load) begin
        run_q  <= '0;
        psum_q <= '0;
        cnt_q  <= '0;
      end else if (!cnt_full) begin
        run_q  <= run_sum;
        psum_q <= psum_sum;
        cnt_q  <= cnt_take;
      end
    end
  end

  // restoring divide, one quotient bit a cycle
  assign rem_sh   = {rem_q, quot_q[DIVD_W-1]};
  assign quot_bit = rem_sh >= {1'b0, divisor_q};
  assign rem_sub  = rem_sh - {1'b0, divisor_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      quot_q    <= {psum_take, FRAC_W'(0)};
      rem_q     <= '0;
      divisor_q <= cnt_take;
      step_q    <= '0;
      port_q    <= PORT_W'(in_port_i % NUM_PORTS);
    end else if (cmd_i.div_step) begin
      quot_q <= {quot_q[DIVD_W-2:0], quot_bit};
      rem_q  <= quot_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      step_q <= step_q + STEP_W'(1);
    end
  end

  assign sts_o.div_last = step_q == STEP_W'(DIVD_W - 1);

  // one shared multiplier for the two halves of the mean
  assign mul_a = cmd_i.mul_hi ? MUL_LO_W'(quot_q[DIVD_W-1:MUL_LO_W]) : quot_q[MUL_LO_W-1:0];
  assign prod  = mul_a * ns_per_byte_i;

  // recombine and drop the per-byte fraction, then saturate
  assign scaled = {1'b0, hi_prod_q, (MUL_LO_W - NS_FRAC_W)'(0)}
                + SCALE_W'(lo_prod_q[PROD_W-1:NS_FRAC_W]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) begin
      lo_prod_q <= prod;
    end
    if (cmd_i.mul_hi) begin
      hi_prod_q <= prod[HI_PROD_W-1:0];
    end
    if (cmd_i.scale) begin
      sample_q <= (scaled[SCALE_W-1:DELAY_W] != '0) ? '1 : scaled[DELAY_W-1:0];
    end
  end

  // weighted old and new terms
  assign old_val = store_q[port_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.w_old) begin
      old_prod_q <= OLD_PR_W'(old_val) * OLD_PR_W'(W_OLD);
      old_zero_q <= old_val == '0;
    end
    if (cmd_i.w_new) begin
      new_prod_q <= NEW_PR_W'(sample_q) * NEW_PR_W'(W_NEW);
    end
  end

  assign wsum    = WSUM_W'(old_prod_q) + WSUM_W'(new_prod_q);
  assign blended = (wsum[WSUM_W-1:DELAY_W+WGT_W] != '0) ? '1 : wsum[DELAY_W+WGT_W-1:WGT_W];
  assign upd     = old_zero_q ? sample_q : blended;

  // per-port smoothed delays
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NUM_PORTS; p++) begin
        store_q[p] <= '0;
      end
    end else if (cmd_i.emit) begin
      store_q[port_q] <= upd;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_port_q     <= port_q;
      out_sample_q   <= sample_q;
      out_smoothed_q <= upd;
      out_count_q    <= divisor_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_port_o     = out_port_q;
  assign out_sample_o   = out_sample_q;
  assign out_smoothed_o = out_smoothed_q;
  assign out_count_o    = out_count_q;

  // the packet count never passes the snapshot limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_SNAPSHOT))
    else $error("packet count beyond limit");

  // a divide always starts with a non-zero divisor
  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_load |=> divisor_q != '0)
    else $error("zero divisor loaded");

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> rem_q < divisor_q)
    else $error("remainder out of range");

endmodule

// ===== design/queue_delay_ewma_estimator_top.sv =====
// Queueing-delay estimator: takes one port queue snapshot as a stream of packet lengths
// (last packet marked), accumulates byte prefix sums, and on the last packet divides the sum
// of prefix sums by the packet count, scales the mean by ns_per_byte_q16 (register 0, Q16)
// and blends it into that port's smoothed delay with weights 205/256 old, 51/256 new (a
// stored zero is replaced outright); one result per snapshot, delays in ns Q8. Every
// packet that is not last is taken without the input being held off. After the last packet
// the input is held off through the 45-step restoring divider, two passes through the
// shared scaling multiplier, a saturation step, two smoothing steps and the write of the
// result register, which waits while the previous result holds the output register.
module queue_delay_ewma_estimator_top import qde_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  qde_in_if.sink                in_i,
  qde_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  qde_cmd_t         cmd;
  qde_sts_t         sts;
  logic [NS_W-1:0]  ns_q;
  logic             reg_hit;
  logic             in_ready;

  // configuration register
  assign pready  = 1'b1;
  assign reg_hit = paddr[APB_ADDR_W-1 -: REG_IDX_W] == REG_NS_PER_BYTE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ns_q <= NS_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      ns_q <= pwdata[NS_W-1:0];
    end
  end

  assign prdata = reg_hit ? {(APB_DATA_W - NS_W)'(0), ns_q} : '0;

  // controller
  qde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last_in_snapshot),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  assign in_i.ready = in_ready;

  // datapath
  qde_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .ns_per_byte_i  (ns_q),
    .in_port_i      (in_i.port_index),
    .in_bytes_i     (in_i.packet_bytes),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_port_o     (out_o.port_out),
    .out_sample_o   (out_o.sample_delay_q8),
    .out_smoothed_o (out_o.smoothed_delay_q8),
    .out_count_o    (out_o.packets_counted)
  );

endmodule
